// ----- src/lhdd_pkg.sv -----
`timescale 1ns / 1ps

package lhdd_pkg;

   // Histogram geometry and result widths
   localparam int NUM_BINS = 256;
   localparam int BIN_W    = 8;
   localparam int OUT_W    = 24;

   // Command queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Stream field widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - 3 * OUT_W - 1;

   // Opcodes on req_tuser
   localparam logic [1:0] OP_ACCUM  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Result kinds on rsp_tuser
   localparam logic RESULT_BIN     = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   // BT.601 luma weights in 16-bit fixed point (sum is 65536)
   localparam logic [15:0] LUMA_WT_RED   = 16'd19595;
   localparam logic [15:0] LUMA_WT_GREEN = 16'd38470;
   localparam logic [15:0] LUMA_WT_BLUE  = 16'd7471;
   localparam int          LUMA_ACC_W    = 24;

   typedef enum logic [1:0] {
      KIND_ACCUM,
      KIND_READ,
      KIND_FINISH
   } item_kind_type;

   typedef struct packed {
      item_kind_type      kind;
      logic [BIN_W-1:0]   addr;
   } queue_entry_type;

   typedef struct packed {
      logic               rd_en;
      logic [BIN_W-1:0]   rd_addr;
      logic               wr_en;
      logic [BIN_W-1:0]   wr_addr;
      logic               clear_all;
   } bin_ctl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ACC_WR,
      BK_RD_WAIT,
      BK_SUM,
      BK_VERDICT
   } back_state_type;

endpackage

// ----- src/luma_histogram_dark_detect_unit.sv -----
`timescale 1ns / 1ps

// Luma histogram with dark-frame detection. Each pixel transaction (op 0) is
// converted to 8-bit BT.601 luma and bumps one of 256 saturating bins plus the
// frame pixel count; it gives no result. A read transaction (op 1) returns one
// bin. A finish transaction (op 2) returns the count of pixels below
// dark_level, the pixel total and the dark verdict, then clears the frame.
// The front end classifies one transaction per cycle into a 4-entry queue while
// the queue has room; the back end owns the bin memory (256 x COUNT_BITS, one
// read and one write port) and runs one queued command at a time: a pixel is a
// registered read, then a write; a read is a registered read plus any wait for
// rsp_tready; a finish walks the bins below the threshold through the single
// read port, then waits for rsp_tready. The bins need no clearing pass after
// reset or finish. Write csr_wr_data only while no transactions are in flight.
module luma_histogram_dark_detect_unit import lhdd_pkg::*; #(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,    // op
   input  logic [REQ_DATA_W-1:0] req_tdata,    // red, green, blue, bin_index
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,    // result_kind
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // bin_count, dark_pixels, total_pixels,
                                               // is_dark, zero pad
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data   // dark_level
);

   localparam logic [7:0] DARK_LEVEL_RESET = 8'd15;

   logic [7:0]            level_ff, level_in;
   logic                  q_push;
   queue_entry_type       q_push_entry;
   logic                  q_full;
   logic                  q_pop;
   queue_entry_type       q_head;
   logic                  q_empty;
   bin_ctl_type           bin_ctl;
   logic [COUNT_BITS-1:0] bin_wr_data;
   logic [COUNT_BITS-1:0] bin_rd_data;

   // Threshold register
   assign level_in = csr_wr_en ? csr_wr_data : level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= DARK_LEVEL_RESET;
      end else begin
         level_ff <= level_in;
      end
   end

   lhdd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   lhdd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   lhdd_bin_store #(
      .COUNT_BITS (COUNT_BITS)
   ) u_bin_store (
      .clock   (clock),
      .reset   (reset),
      .bin_ctl (bin_ctl),
      .wr_data (bin_wr_data),
      .rd_data (bin_rd_data)
   );

   lhdd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .dark_level  (level_ff),
      .bin_ctl     (bin_ctl),
      .bin_wr_data (bin_wr_data),
      .bin_rd_data (bin_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- src/lhdd_front.sv -----
`timescale 1ns / 1ps

module lhdd_front import lhdd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // op
   input  logic [REQ_DATA_W-1:0] req_tdata,   // red, green, blue, bin_index
   input  logic                  q_full,
   output logic                  q_push,
   output queue_entry_type       q_push_entry
);

   logic [7:0]            red;
   logic [7:0]            green;
   logic [7:0]            blue;
   logic [BIN_W-1:0]      bin_index;
   logic [LUMA_ACC_W-1:0] luma_acc;
   logic [BIN_W-1:0]      luma;
   logic                  accept;
   logic                  cls_valid;
   queue_entry_type       cls_entry;
   logic                  valid_ff, valid_in;
   queue_entry_type       entry_ff, entry_in;

   // Unpack the transaction payload
   assign red       = req_tdata[7:0];
   assign green     = req_tdata[15:8];
   assign blue      = req_tdata[23:16];
   assign bin_index = req_tdata[31:24];

   // Weighted sum of the color components, keep the integer part
   assign luma_acc = LUMA_ACC_W'(red)   * LUMA_ACC_W'(LUMA_WT_RED)
                   + LUMA_ACC_W'(green) * LUMA_ACC_W'(LUMA_WT_GREEN)
                   + LUMA_ACC_W'(blue)  * LUMA_ACC_W'(LUMA_WT_BLUE);
   assign luma = luma_acc[LUMA_ACC_W-1:LUMA_ACC_W-BIN_W];

   // Classify the opcode; the unused code is dropped here
   always_comb begin
      cls_valid      = 1'b1;
      cls_entry.kind = KIND_ACCUM;
      cls_entry.addr = luma;
      case (req_tuser)
         OP_ACCUM: begin
            cls_entry.kind = KIND_ACCUM;
            cls_entry.addr = luma;
         end
         OP_READ: begin
            cls_entry.kind = KIND_READ;
            cls_entry.addr = bin_index;
         end
         OP_FINISH: begin
            cls_entry.kind = KIND_FINISH;
            cls_entry.addr = '0;
         end
         default: begin
            cls_valid = 1'b0;
         end
      endcase
   end

   // Hold one classified entry until the queue takes it
   assign q_push       = valid_ff && !q_full;
   assign q_push_entry = entry_ff;
   assign req_tready   = !valid_ff || !q_full;
   assign accept       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (accept) begin
         valid_in = cls_valid;
         entry_in = cls_entry;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- src/lhdd_queue.sv -----
`timescale 1ns / 1ps

module lhdd_queue import lhdd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output queue_entry_type head,
   output logic            empty
);

   queue_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/lhdd_bin_store.sv -----
`timescale 1ns / 1ps

module lhdd_bin_store import lhdd_pkg::*; #(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bin_ctl_type           bin_ctl,
   input  logic [COUNT_BITS-1:0] wr_data,
   output logic [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0] mem_ff [NUM_BINS];
   logic [COUNT_BITS-1:0] rd_q_ff;
   logic                  rd_valid_ff;
   logic [NUM_BINS-1:0]   valid_ff, valid_in;

   // Simple dual-port style array: one write, one registered read
   always_ff @(posedge clock) begin
      if (bin_ctl.wr_en) begin
         mem_ff[bin_ctl.wr_addr] <= wr_data;
      end
      if (bin_ctl.rd_en) begin
         rd_q_ff <= mem_ff[bin_ctl.rd_addr];
      end
   end

   // Track written bins; a finish drops them all at once
   always_comb begin
      valid_in = valid_ff;
      if (bin_ctl.clear_all) begin
         valid_in = '0;
      end else if (bin_ctl.wr_en) begin
         valid_in[bin_ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (bin_ctl.rd_en) begin
            rd_valid_ff <= valid_ff[bin_ctl.rd_addr];
         end
      end
   end

   // An unwritten bin reads as zero
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// ----- src/lhdd_back.sv -----
`timescale 1ns / 1ps

module lhdd_back import lhdd_pkg::*; #(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_entry_type       q_head,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic [7:0]            dark_level,
   output bin_ctl_type           bin_ctl,
   output logic [COUNT_BITS-1:0] bin_wr_data,
   input  logic [COUNT_BITS-1:0] bin_rd_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,   // result_kind
   output logic [RSP_DATA_W-1:0] rsp_tdata    // bin_count, dark_pixels, total_pixels,
                                              // is_dark, zero pad
);

   localparam int WIDE_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   back_state_type        state_ff, state_in;
   logic [BIN_W-1:0]      addr_ff, addr_in;
   logic [BIN_W:0]        idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [COUNT_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] pixel_ff, pixel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [OUT_W-1:0]      rsp_bin_ff, rsp_bin_in;
   logic [OUT_W-1:0]      rsp_dark_ff, rsp_dark_in;
   logic [OUT_W-1:0]      rsp_total_ff, rsp_total_in;
   logic                  rsp_flag_ff, rsp_flag_in;

   logic                  out_free;
   logic                  walk_rd;
   logic                  acc_write;
   logic                  load_bin;
   logic                  load_verdict;
   logic [COUNT_BITS:0]   sum_wide;
   logic [COUNT_BITS-1:0] sum_sat;
   logic [COUNT_BITS-1:0] pixel_inc;
   logic [WIDE_W-1:0]     rd_wide;
   logic [WIDE_W-1:0]     sum_out_wide;
   logic [WIDE_W-1:0]     pixel_out_wide;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign walk_rd  = (idx_ff < {1'b0, dark_level});

   // Saturating arithmetic
   assign bin_wr_data = (bin_rd_data == CNT_MAX) ? bin_rd_data
                                                 : bin_rd_data + COUNT_BITS'(1);
   assign pixel_inc   = (pixel_ff == CNT_MAX) ? pixel_ff : pixel_ff + COUNT_BITS'(1);
   assign sum_wide    = {1'b0, sum_ff} + {1'b0, bin_rd_data};
   assign sum_sat     = sum_wide[COUNT_BITS] ? CNT_MAX : sum_wide[COUNT_BITS-1:0];

   // Fit counters to the result field width
   assign rd_wide        = WIDE_W'(bin_rd_data);
   assign sum_out_wide   = WIDE_W'(sum_ff);
   assign pixel_out_wide = WIDE_W'(pixel_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  KIND_ACCUM:  state_in = BK_ACC_WR;
                  KIND_READ:   state_in = BK_RD_WAIT;
                  KIND_FINISH: state_in = BK_SUM;
                  default:     state_in = BK_IDLE;
               endcase
            end
         end
         BK_ACC_WR: begin
            state_in = BK_IDLE;
         end
         BK_RD_WAIT: begin
            if (out_free) state_in = BK_IDLE;
         end
         BK_SUM: begin
            if (!walk_rd && !pend_ff) state_in = BK_VERDICT;
         end
         BK_VERDICT: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control outputs per state
   always_comb begin
      q_pop        = 1'b0;
      bin_ctl      = '0;
      acc_write    = 1'b0;
      load_bin     = 1'b0;
      load_verdict = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop           = !q_empty;
            bin_ctl.rd_en   = !q_empty && (q_head.kind == KIND_ACCUM ||
                                           q_head.kind == KIND_READ);
            bin_ctl.rd_addr = q_head.addr;
         end
         BK_ACC_WR: begin
            acc_write       = 1'b1;
            bin_ctl.wr_en   = 1'b1;
            bin_ctl.wr_addr = addr_ff;
         end
         BK_RD_WAIT: begin
            load_bin = out_free;
         end
         BK_SUM: begin
            bin_ctl.rd_en   = walk_rd;
            bin_ctl.rd_addr = idx_ff[BIN_W-1:0];
         end
         BK_VERDICT: begin
            load_verdict      = out_free;
            bin_ctl.clear_all = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      addr_in      = q_pop ? q_head.addr : addr_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      pend_in      = (state_ff == BK_SUM) && walk_rd;
      pixel_in     = pixel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_dark_in  = rsp_dark_ff;
      rsp_total_in = rsp_total_ff;
      rsp_flag_in  = rsp_flag_ff;

      // Walk the dark bins, one read issued per cycle
      if (q_pop) begin
         idx_in = '0;
         sum_in = '0;
      end else if (state_ff == BK_SUM) begin
         if (walk_rd) idx_in = idx_ff + 1'b1;
         if (pend_ff) sum_in = sum_sat;
      end

      if (acc_write) begin
         pixel_in = pixel_inc;
      end else if (load_verdict) begin
         pixel_in = '0;
      end

      // Output register: load a result or drain on handshake
      if (load_bin) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = RESULT_BIN;
         rsp_bin_in   = rd_wide[OUT_W-1:0];
         rsp_dark_in  = '0;
         rsp_total_in = '0;
         rsp_flag_in  = 1'b0;
      end else if (load_verdict) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = RESULT_VERDICT;
         rsp_bin_in   = '0;
         rsp_dark_in  = sum_out_wide[OUT_W-1:0];
         rsp_total_in = pixel_out_wide[OUT_W-1:0];
         rsp_flag_in  = (sum_ff > (pixel_ff >> 1));
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pend_ff      <= 1'b0;
         pixel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         pixel_ff     <= pixel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_dark_ff  <= rsp_dark_in;
      rsp_total_ff <= rsp_total_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_flag_ff, rsp_total_ff, rsp_dark_ff, rsp_bin_ff};

   // A pixel update is a single read then a single write
   a_acc_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ACC_WR) |=> (state_ff == BK_IDLE))
      else $error("accumulate write did not return to idle");

   // Dark sum is a subset of the pixels counted so far
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SUM) |-> (sum_ff <= pixel_ff))
      else $error("dark sum exceeds pixel total");

   // A verdict loaded for output starts a fresh frame
   a_verdict_clears: assert property (@(posedge clock) disable iff (reset)
      load_verdict |=> (pixel_ff == '0 && state_ff == BK_IDLE && rsp_tvalid))
      else $error("frame state not cleared after verdict");

endmodule
